### rtl/tkf_pkg.sv
// Shared types and constants for the tilt Kalman filter.
// Depends on nothing; the top level imports it.
`default_nettype none
package tkf_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DSET,
      ST_DRUN,
      ST_DEND
   } state_type;

   // Multiply-accumulate operations, in the order the sequencer runs them.
   typedef logic [3:0] op_type;
   localparam op_type OP_ANGLE_PRED = 4'd0;
   localparam op_type OP_P00_PRED   = 4'd1;
   localparam op_type OP_P01_PRED   = 4'd2;
   localparam op_type OP_P10_PRED   = 4'd3;
   localparam op_type OP_P11_PRED   = 4'd4;
   localparam op_type OP_P10_UPD    = 4'd5;
   localparam op_type OP_P11_UPD    = 4'd6;
   localparam op_type OP_P00_UPD    = 4'd7;
   localparam op_type OP_P01_UPD    = 4'd8;
   localparam op_type OP_BIAS_UPD   = 4'd9;
   localparam op_type OP_ANGLE_UPD  = 4'd10;

   // Configuration register indexes.
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_QA = 2'd0;
   localparam csr_idx_type CSR_QB = 2'd1;
   localparam csr_idx_type CSR_R  = 2'd2;
   localparam csr_idx_type CSR_DT = 2'd3;

   // Reset values, Q2.30.
   localparam logic [30:0] QA_RESET  = 31'd1073742;
   localparam logic [30:0] QB_RESET  = 31'd3221225;
   localparam logic [30:0] R_RESET   = 31'd536870912;
   localparam logic [30:0] DT_RESET  = 31'd5368709;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

### rtl/tilt_kalman_filter_top.sv
// Two-state tilt Kalman filter (angle and gyro bias) on one shared multiplier.
// Depends on tkf_pkg.
//
// Usage:
//   req channel: one transaction carries accel_angle (tdata[31:0]) and
//   gyro_rate (tdata[63:32]), both signed Q16.16.
//   rsp channel: one transaction per input, angle_estimate (tdata[31:0]) and
//   rate_estimate (tdata[63:32]), signed Q16.16, saturated.
//   csr port: write enable, 2-bit register index and 31-bit data; registers
//   are angle process noise, bias process noise, measurement noise, dt.
// Operation: the 33x33 multiplier serves eleven products, each in a multiply
// state followed by an accumulate state, and the two gains each come from a
// radix-2 restoring divider (a setup state, shift-subtract steps, an end
// state). req_tready is high only while the sequencer is idle, so the next
// item is not accepted until the previous one has been through all its steps.
// Reset (synchronous, active high) restores the register defaults, clears
// angle and bias and sets the covariance to identity.
// Stall: the result sits in an output register; a new item may be accepted
// while it waits, and the sequencer holds at its final step until that
// register is free.
`default_nettype none
module tilt_kalman_filter_top (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // [31:0] accel_angle, [63:32] gyro_rate
   input  wire  [63:0]             req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // [31:0] angle_estimate, [63:32] rate_estimate
   output logic [63:0]             rsp_tdata,
   input  wire                     csr_wr_en,
   input  wire  tkf_pkg::csr_idx_type csr_index,
   input  wire  [30:0]             csr_wr_data
);
   import tkf_pkg::*;

   // Saturate a 38-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sh0_7FFF_FFFF) r = SAT_MAX;
      else if (v < -38'sh0_8000_0000) r = SAT_MIN;
      else r = v[31:0];
      return r;
   endfunction

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      sel_ff, sel_in;
   logic [4:0] cnt_ff, cnt_in;

   logic [30:0] qa_ff, qb_ff, r_ff, dt_ff;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] accel_ff, accel_in, gyro_ff, gyro_in;
   logic signed [65:0] prod_ff, prod_in;

   logic [32:0] den_ff, den_in, rem_ff, rem_in;
   logic [31:0] numlo_ff, numlo_in, quo_ff, quo_in;
   logic        neg_ff, neg_in, ovf_ff, ovf_in, zden_ff, zden_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   // Operand selection for the current operation.
   logic signed [32:0] op_a, op_b;
   logic signed [31:0] op_base;
   logic               op_sub;
   logic signed [33:0] d0_wide;
   logic signed [31:0] d0;
   logic signed [32:0] rate_raw, err;

   always_comb begin
      d0_wide  = $signed({3'b000, qa_ff}) - 34'(p01_ff) - 34'(p10_ff);
      d0       = sat38(38'(d0_wide));
      rate_raw = 33'(gyro_ff) - 33'(bias_ff);
      err      = 33'(accel_ff) - 33'(angle_ff);
      op_a     = 33'(p11_ff);
      op_b     = $signed({2'b00, dt_ff});
      op_base  = angle_ff;
      op_sub   = 1'b0;
      case (op_ff)
         OP_ANGLE_PRED: begin op_a = rate_raw;      op_base = angle_ff; end
         OP_P00_PRED:   begin op_a = 33'(d0);       op_base = p00_ff; end
         OP_P01_PRED:   begin op_base = p01_ff; op_sub = 1'b1; end
         OP_P10_PRED:   begin op_base = p10_ff; op_sub = 1'b1; end
         OP_P11_PRED:   begin op_a = $signed({2'b00, qb_ff}); op_base = p11_ff; end
         OP_P10_UPD:    begin op_a = 33'(k1_ff); op_b = 33'(p00_ff);
                              op_base = p10_ff; op_sub = 1'b1; end
         OP_P11_UPD:    begin op_a = 33'(k1_ff); op_b = 33'(p01_ff);
                              op_base = p11_ff; op_sub = 1'b1; end
         OP_P00_UPD:    begin op_a = 33'(k0_ff); op_b = 33'(p00_ff);
                              op_base = p00_ff; op_sub = 1'b1; end
         OP_P01_UPD:    begin op_a = 33'(k0_ff); op_b = 33'(p01_ff);
                              op_base = p01_ff; op_sub = 1'b1; end
         OP_BIAS_UPD:   begin op_a = 33'(k1_ff); op_b = err; op_base = bias_ff; end
         OP_ANGLE_UPD:  begin op_a = 33'(k0_ff); op_b = err; op_base = angle_ff; end
         default: ;
      endcase
   end

   // Rescale the registered product by 2^-30 with ties away from zero,
   // then add it to or subtract it from the base and saturate.
   logic signed [65:0] rnd;
   logic signed [65:0] shr;
   logic signed [35:0] scaled;
   logic signed [37:0] acc_sum;
   logic signed [31:0] acc_res;

   always_comb begin
      rnd     = prod_ff + (prod_ff[65] ? 66'sd536870911 : 66'sd536870912);
      shr     = rnd >>> 30;
      scaled  = shr[35:0];
      acc_sum = op_sub ? (38'(op_base) - 38'(scaled)) : (38'(op_base) + 38'(scaled));
      acc_res = sat38(acc_sum);
   end

   // Divider setup and step terms.
   logic signed [31:0] div_num;
   logic signed [33:0] den_wide;
   logic [32:0]        pmag;
   logic [33:0]        div_sh;
   logic               div_ge;
   logic signed [31:0] gain_res;
   logic               out_free;

   always_comb begin
      div_num  = sel_ff ? p10_ff : p00_ff;
      den_wide = $signed({3'b000, r_ff}) + 34'(p00_ff);
      pmag     = div_num[31] ? (33'd0 - 33'(div_num)) : 33'(div_num);
      div_sh   = {rem_ff, numlo_ff[31]};
      div_ge   = div_sh >= {1'b0, den_ff};
      if (zden_ff) gain_res = 32'sd0;
      else if (ovf_ff || quo_ff[31]) gain_res = neg_ff ? SAT_MIN : SAT_MAX;
      else gain_res = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // Sequencer next state and datapath next values.
   always_comb begin
      state_in = state_ff;  op_in = op_ff;  sel_in = sel_ff;  cnt_in = cnt_ff;
      angle_in = angle_ff;  bias_in = bias_ff;
      p00_in = p00_ff;  p01_in = p01_ff;  p10_in = p10_ff;  p11_in = p11_ff;
      k0_in = k0_ff;  k1_in = k1_ff;  accel_in = accel_ff;  gyro_in = gyro_ff;
      prod_in = prod_ff;  den_in = den_ff;  rem_in = rem_ff;
      numlo_in = numlo_ff;  quo_in = quo_ff;
      neg_in = neg_ff;  ovf_in = ovf_ff;  zden_in = zden_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               accel_in = $signed(req_tdata[31:0]);
               gyro_in  = $signed(req_tdata[63:32]);
               op_in    = OP_ANGLE_PRED;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = op_a * op_b;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (op_ff != OP_ANGLE_UPD || out_free) begin
               case (op_ff) inside
                  OP_ANGLE_PRED, OP_ANGLE_UPD: angle_in = acc_res;
                  OP_P00_PRED, OP_P00_UPD:     p00_in = acc_res;
                  OP_P01_PRED, OP_P01_UPD:     p01_in = acc_res;
                  OP_P10_PRED, OP_P10_UPD:     p10_in = acc_res;
                  OP_P11_PRED, OP_P11_UPD:     p11_in = acc_res;
                  OP_BIAS_UPD:                 bias_in = acc_res;
                  default: ;
               endcase
               if (op_ff == OP_P11_PRED) begin
                  sel_in   = 1'b0;
                  state_in = ST_DSET;
               end else if (op_ff == OP_ANGLE_UPD) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {sat38(38'(gyro_ff) - 38'(bias_ff)), acc_res};
                  state_in     = ST_IDLE;
               end else begin
                  op_in    = op_ff + 4'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_DSET: begin
            zden_in  = (den_wide <= 34'sd0);
            den_in   = den_wide[32:0];
            neg_in   = div_num[31];
            ovf_in   = {2'b00, pmag} >= {den_wide[32:0], 2'b00};
            rem_in   = {2'b00, pmag[32:2]};
            numlo_in = {pmag[1:0], 30'd0};
            cnt_in   = 5'd31;
            state_in = ST_DRUN;
         end
         ST_DRUN: begin
            rem_in   = div_ge ? 33'(div_sh - {1'b0, den_ff}) : div_sh[32:0];
            numlo_in = {numlo_ff[30:0], 1'b0};
            quo_in   = {quo_ff[30:0], div_ge};
            cnt_in   = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = ST_DEND;
         end
         ST_DEND: begin
            if (!sel_ff) begin
               k0_in    = gain_res;
               sel_in   = 1'b1;
               state_in = ST_DSET;
            end else begin
               k1_in    = gain_res;
               op_in    = OP_P10_UPD;
               state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and filter state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ANGLE_PRED;
         sel_ff       <= 1'b0;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= 32'sd0;
         bias_ff      <= 32'sd0;
         p00_ff       <= ONE_Q30;
         p01_ff       <= 32'sd0;
         p10_ff       <= 32'sd0;
         p11_ff       <= ONE_Q30;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
      end
   end

   // Datapath payload registers.
   always_ff @(posedge clock) begin
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      accel_ff    <= accel_in;
      gyro_ff     <= gyro_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      numlo_ff    <= numlo_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      ovf_ff      <= ovf_in;
      zden_ff     <= zden_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= QA_RESET;
         qb_ff <= QB_RESET;
         r_ff  <= R_RESET;
         dt_ff <= DT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_QA: qa_ff <= csr_wr_data;
            CSR_QB: qb_ff <= csr_wr_data;
            CSR_R:  r_ff  <= csr_wr_data;
            CSR_DT: dt_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/tkf_checker.sv
// Port-level checks for the tilt Kalman filter, bound to the top level.
// Depends on tilt_kalman_filter_top.
`default_nettype none
module tkf_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata
);

   // The filter stays busy after taking a transaction.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready)
      else $error("req_tready high right after a request");

   // A result only appears at the end of a busy period.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while idle");

   // After reset no result is pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind tilt_kalman_filter_top tkf_checker u_tkf_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

### verif/tilt_kalman_filter_checker.sv
// Checker for the tilt Kalman filter: watches the csr port and both streams,
// predicts each result from its own filter state and compares. Needs tkf_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tilt_kalman_filter_checker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   input  wire                       req_tready,
   input  wire  [63:0]               req_tdata,
   input  wire                       rsp_tvalid,
   input  wire                       rsp_tready,
   input  wire  [63:0]               rsp_tdata,
   input  wire                       csr_wr_en,
   input  wire  tkf_pkg::csr_idx_type csr_index,
   input  wire  [30:0]               csr_wr_data,
   output int                        fail_count,
   output int                        pending_count
);
   import tkf_pkg::*;

   typedef struct packed {
      logic signed [31:0] rate_estimate;
      logic signed [31:0] angle_estimate;
   } estimate_type;

   // Filter registers and state mirrored by the predictor.
   logic [30:0] qa, qb, rn, dt;
   longint angle, bias;
   longint cov [4];
   estimate_type estimate_queue [$];

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Shift right by 30 with rounding to nearest, ties away from zero.
   function automatic longint round_q30(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< 29)) >>> 30;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint kalman_gain(longint num, longint den);
      if (den <= 0) return 0;
      return sat32((num * (64'sd1 <<< 30)) / den);
   endfunction

   // One predict and update step; returns the expected estimates.
   function automatic estimate_type filter_step(logic [63:0] sample);
      longint accel, gyro, step, p00, p01, p10, p11, d0, e, k0, k1, err;
      estimate_type r;
      accel = longint'($signed(sample[31:0]));
      gyro  = longint'($signed(sample[63:32]));
      step  = longint'(dt);
      angle = sat32(angle + round_q30((gyro - bias) * step));
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      d0  = sat32(longint'(qa) - p01 - p10);
      p00 = sat32(p00 + round_q30(d0 * step));
      p01 = sat32(p01 - round_q30(p11 * step));
      p10 = sat32(p10 - round_q30(p11 * step));
      p11 = sat32(p11 + round_q30(longint'(qb) * step));
      e  = longint'(rn) + p00;
      k0 = kalman_gain(p00, e);
      k1 = kalman_gain(p10, e);
      // The P11 update uses P01 as predicted, before its own update.
      cov[0] = sat32(p00 - round_q30(k0 * p00));
      cov[1] = sat32(p01 - round_q30(k0 * p01));
      cov[2] = sat32(p10 - round_q30(k1 * p00));
      cov[3] = sat32(p11 - round_q30(k1 * p01));
      err   = accel - angle;
      angle = sat32(angle + round_q30(k0 * err));
      bias  = sat32(bias + round_q30(k1 * err));
      r.angle_estimate = angle[31:0];
      r.rate_estimate  = 32'(sat32(gyro - bias));
      return r;
   endfunction

   assign pending_count = estimate_queue.size();

   always @(posedge clock) begin
      estimate_type want, got;
      int errs;
      errs = 0;
      if (reset) begin
         qa <= QA_RESET; qb <= QB_RESET; rn <= R_RESET; dt <= DT_RESET;
         angle = 0; bias = 0;
         cov[0] = ONE_Q30; cov[1] = 0; cov[2] = 0; cov[3] = ONE_Q30;
         estimate_queue.delete();
         fail_count <= 0;
      end else begin
         // Register writes.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_QA: qa <= csr_wr_data;
               CSR_QB: qb <= csr_wr_data;
               CSR_R: rn <= csr_wr_data;
               CSR_DT: dt <= csr_wr_data;
               default: ;
            endcase
         end
         // Input transaction: predict its result.
         if (req_tvalid && req_tready) estimate_queue.push_back(filter_step(req_tdata));
         // Result transaction: compare with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (estimate_queue.size() == 0) begin
               $error("result with no transaction pending: %h", rsp_tdata);
               errs++;
            end else begin
               want = estimate_queue.pop_front();
               if (got.angle_estimate !== want.angle_estimate) begin
                  $error("angle_estimate expected %0d actual %0d",
                         want.angle_estimate, got.angle_estimate);
                  errs++;
               end
               if (got.rate_estimate !== want.rate_estimate) begin
                  $error("rate_estimate expected %0d actual %0d",
                         want.rate_estimate, got.rate_estimate);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule
`default_nettype wire

### verif/tilt_kalman_filter_top_test.sv
// Testbench top for the tilt Kalman filter: clock, reset, csr writes,
// sample stimulus with random gaps and the verdict. Needs tkf_pkg and the checker.
`timescale 1ns / 100ps
`default_nettype none
module tilt_kalman_filter_top_test;
   import tkf_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_SAMPLES = 480;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tready = 0;
   logic        csr_wr_en = 0;
   csr_idx_type csr_index = CSR_QA;
   logic [30:0] csr_wr_data = '0;
   wire         req_tready, rsp_tvalid;
   wire  [63:0] rsp_tdata;
   int          fail_count, pending_count;
   int          idle_cycles = 0;
   bit          quiet_phase = 0;
   bit          long_hold = 0;

   always #5 clock = ~clock;

   tilt_kalman_filter_top u_top (.*);
   tilt_kalman_filter_checker u_checker (.*);

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tilt_kalman_filter_top regression: fail");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold, none at the end.
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (600) @(posedge clock);
            long_hold = 0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // One register write, followed by a cycle with the write enable low.
   task automatic write_csr(csr_idx_type idx, logic [30:0] value);
      csr_wr_en <= 1; csr_index <= idx; csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // Stops offering, waits for all results, then for the block to go quiet.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock iff pending_count == 0);
      repeat (100) @(posedge clock);
   endtask

   // Offers one sample; tvalid stays up until the next sample, a gap or a drain.
   task automatic send_sample(logic [31:0] accel, logic [31:0] gyro, bit gaps);
      int n;
      if (gaps && !quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         n = $urandom_range(1, 14);
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {gyro, accel};
      @(posedge clock iff req_tready);
   endtask

   // Mostly a bounded tilt around a slowly drifting value, with noise; at times random or full-scale.
   task automatic random_sample(int k);
      logic [31:0] a, g;
      case ($urandom_range(0, 9))
         0: begin a = $urandom; g = $urandom; end
         1: begin a = 32'h7FFF_FFFF; g = 32'h8000_0000; end
         default: begin
            a = 32'(((k % 90) - 45) * 65536 + int'($urandom_range(0, 131071)) - 65536);
            g = 32'(int'($urandom_range(0, 2000000)) - 1000000);
         end
      endcase
      send_sample(a, g, 1'b1);
   endtask

   initial begin
      logic [30:0] qa_set [4] = '{31'd0, 31'h7FFF_FFFF, 31'd1073742, 31'd50000};
      logic [30:0] qb_set [4] = '{31'd0, 31'h7FFF_FFFF, 31'd3221225, 31'd100};
      logic [30:0] r_set  [4] = '{31'd1, 31'h7FFF_FFFF, 31'd536870912, 31'd100000};
      logic [30:0] dt_set [4] = '{31'd1, 31'h7FFF_FFFF, 31'd5368709, 31'd53687091};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes at reset settings.
      send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
      send_sample(32'h000A_0000, 32'hFFF6_0000, 1'b0);
      drain();
      // Zero process noise, minimum measurement noise and minimum period.
      write_csr(CSR_QA, 31'd0); write_csr(CSR_QB, 31'd0); write_csr(CSR_R, 31'd1);
      write_csr(CSR_DT, 31'd1);
      repeat (4) send_sample($urandom, $urandom, 1'b0);
      drain();
      write_csr(CSR_QA, 31'h7FFF_FFFF); write_csr(CSR_QB, 31'h7FFF_FFFF);
      write_csr(CSR_R, 31'h7FFF_FFFF); write_csr(CSR_DT, 31'h7FFF_FFFF);
      repeat (4) send_sample($urandom, $urandom, 1'b0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      drain();

      // Random phases over several settings, the register extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_QA, phase < 4 ? qa_set[phase] : 31'($urandom));
         write_csr(CSR_QB, phase < 4 ? qb_set[phase ^ 1] : 31'($urandom));
         write_csr(CSR_R, phase < 4 ? r_set[phase] : 31'($urandom_range(1, 32'h7FFF_FFFF)));
         write_csr(CSR_DT, phase < 4 ? dt_set[phase] : 31'($urandom_range(1, 32'h7FFFFF)));
         if (phase == 2) long_hold = 1;
         if (phase == 5) quiet_phase = 1;
         for (int k = 0; k < RANDOM_SAMPLES / 6; k++) random_sample(k);
         // Sender pause until every result is back.
         drain();
      end

      if (fail_count == 0) $display("tilt_kalman_filter_top regression: pass");
      else $display("tilt_kalman_filter_top regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

### tilt_kalman_filter_top.f
rtl/tkf_pkg.sv
rtl/tilt_kalman_filter_top.sv
rtl/tkf_checker.sv
verif/tilt_kalman_filter_checker.sv
verif/tilt_kalman_filter_top_test.sv
